// ===== rtl/radix_digit_converter_core_macros.svh =====
// Assertion helpers for the converter RTL.
`ifndef RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define RDC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define RDC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

    localparam int VALUE_W = 16;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int S_TDATA_W = 24;   // value + radix, padded to bytes
    localparam int M_TDATA_W = 8;    // digit_char, padded to a byte

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [RADIX_W-1:0] t_radix;
    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    localparam t_radix RADIX_MIN = 5'd2;
    localparam t_radix RADIX_MAX = 5'd16;
    localparam t_digit DEC_LIMIT = 4'd10;
    localparam t_char  ASCII_ZERO = 7'd48;      // '0'
    localparam t_char  ASCII_ALPHA_OFS = 7'd55; // 'A' - 10

    function automatic t_char digit_to_ascii(input t_digit d);
        t_char ofs;
        ofs = (d >= DEC_LIMIT) ? ASCII_ALPHA_OFS : ASCII_ZERO;
        return {3'b000, d} + ofs;
    endfunction

endpackage

// ===== rtl/radix_digit_converter_core.sv =====
// Unsigned 16-bit to base-N ASCII converter. One input word carries a value
// and a radix (clamped to 2..16); the block returns the value's digits most
// significant first, one output word per digit, '0'-'9' then 'A'-'F', with
// tlast on the least significant digit. A value of zero gives a single '0'.
// The digits come from one shared restoring divider that produces one
// quotient bit per cycle, with one full division per digit; they are kept
// in a small digit store and then read back in reverse, one word per cycle
// while the sink is ready. s_axis_tready is high only between items; the
// last digit waits in the output register, so the next item can be taken
// while it is pending.
`include "radix_digit_converter_core_macros.svh"

module radix_digit_converter_core #(
    parameter int DIGIT_SLOTS = 16   // digit store depth, 16..32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] value, [20:16] radix, [23:21] zero
    input  logic [rdc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [6:0] digit_char, [7] zero
    output logic [rdc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam int IDX_W = $clog2(DIGIT_SLOTS);
    localparam int BIT_W = $clog2(rdc_pkg::VALUE_W);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(DIGIT_SLOTS - 1);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(rdc_pkg::VALUE_W - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             r_state, n_state;
    rdc_pkg::t_value        r_quot;      // dividend, becomes quotient
    rdc_pkg::t_digit        r_rem;       // partial remainder, always < radix
    rdc_pkg::t_radix        r_radix;
    logic [BIT_W-1:0]       r_bit;
    logic [IDX_W-1:0]       r_wr;        // next digit slot to fill
    logic [IDX_W-1:0]       r_idx;       // next digit slot to emit
    logic                   r_out_valid;
    rdc_pkg::t_char         r_out_char;
    logic                   r_out_last;
    rdc_pkg::t_digit        r_mem [DIGIT_SLOTS];

    rdc_pkg::t_value        w_in_value;
    rdc_pkg::t_radix        w_in_radix;
    rdc_pkg::t_radix        w_radix_clamp;
    logic                   w_accept;
    logic [rdc_pkg::RADIX_W-1:0] w_trial;
    logic                   w_ge;
    rdc_pkg::t_digit        w_rem_nx;
    rdc_pkg::t_value        w_quot_nx;
    logic                   w_digit_done;
    logic                   w_conv_done;
    logic                   w_out_free;
    logic                   w_mem_we;
    logic [IDX_W-1:0]       w_mem_addr;
    rdc_pkg::t_digit        w_mem_wdata;

    assign w_in_value = s_axis_tdata[rdc_pkg::VALUE_W-1:0];
    assign w_in_radix = s_axis_tdata[rdc_pkg::VALUE_W +: rdc_pkg::RADIX_W];
    assign w_radix_clamp = (w_in_radix < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN :
                           (w_in_radix > rdc_pkg::RADIX_MAX) ? rdc_pkg::RADIX_MAX :
                           w_in_radix;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // one restoring-division step: shift in the next dividend bit, subtract
    assign w_trial   = {r_rem, r_quot[rdc_pkg::VALUE_W-1]};
    assign w_ge      = (w_trial >= r_radix);
    assign w_rem_nx  = w_ge ? rdc_pkg::DIGIT_W'(w_trial - r_radix)
                            : rdc_pkg::DIGIT_W'(w_trial);
    assign w_quot_nx = {r_quot[rdc_pkg::VALUE_W-2:0], w_ge};

    assign w_digit_done = (r_state == ST_DIV) && (r_bit == BIT_TOP);
    assign w_conv_done  = w_digit_done && ((w_quot_nx == '0) || (r_wr == IDX_TOP));

    assign w_out_free = !r_out_valid || m_axis_tready;

    // digit store write: zero value on accept, else each finished remainder
    assign w_mem_we    = (w_accept && (w_in_value == '0)) || w_digit_done;
    assign w_mem_addr  = (r_state == ST_IDLE) ? '0 : r_wr;
    assign w_mem_wdata = (r_state == ST_IDLE) ? '0 : w_rem_nx;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_in_value == '0) ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_conv_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free && (r_idx == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        // registered read of the store straight into the output word
        if ((r_state == ST_EMIT) && w_out_free) begin
            r_out_char <= rdc_pkg::digit_to_ascii(r_mem[r_idx]);
            r_out_last <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bit       <= '0;
            r_wr        <= '0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_quot  <= w_in_value;
                        r_radix <= w_radix_clamp;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_wr    <= '0;
                        r_idx   <= '0;
                    end
                end
                ST_DIV: begin
                    r_bit <= r_bit + 1'b1;
                    if (w_digit_done) begin
                        // quotient feeds the next digit, remainder restarts
                        r_quot <= w_quot_nx;
                        r_rem  <= '0;
                        if (w_conv_done) begin
                            r_idx <= r_wr;
                        end else begin
                            r_wr <= r_wr + 1'b1;
                        end
                    end else begin
                        r_quot <= w_quot_nx;
                        r_rem  <= w_rem_nx;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free && (r_idx != '0)) begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                default: ;
            endcase
            if ((r_state == ST_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_char};
    assign m_axis_tlast  = r_out_last;

    `RDC_ASSERT_IMP(a_rem_below_radix, i_clk, i_rst_n, (r_state == ST_DIV), (r_rem < r_radix), "remainder reached radix")
    `RDC_ASSERT_IMP(a_radix_range, i_clk, i_rst_n, (r_state == ST_DIV), ((r_radix >= rdc_pkg::RADIX_MIN) && (r_radix <= rdc_pkg::RADIX_MAX)), "radix out of range")
    `RDC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, (!s_axis_tready), "ready high after accept")
    `RDC_ASSERT_NXT(a_idle_after_last, i_clk, i_rst_n, ((r_state == ST_EMIT) && w_out_free && (r_idx == '0)), (s_axis_tready && m_axis_tvalid && m_axis_tlast), "last digit not followed by idle")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// Holds the ASCII digits still owed by the converter and checks each output word.
class digit_scoreboard;

    typedef struct packed {
        rdc_pkg::t_char ch;
        logic           last;
    } t_digit_word;

    localparam int          MAX_DIGITS   = 16;
    localparam int unsigned DECIMAL_SPAN = 10;
    localparam int unsigned CHAR_ZERO    = 48;   // '0'
    localparam int unsigned CHAR_UPPER_A = 65;   // 'A'

    t_digit_word expected_digits[$];
    int          error_count = 0;

    // Splits an accepted value into digits, most significant first.
    function void note_word(rdc_pkg::t_value value, rdc_pkg::t_radix radix);
        int unsigned    v;
        int unsigned    r;
        int unsigned    n;
        int unsigned    code;
        rdc_pkg::t_digit remainders[MAX_DIGITS];
        t_digit_word    w;
        v = value;
        r = radix;
        if (r < rdc_pkg::RADIX_MIN) r = rdc_pkg::RADIX_MIN;
        if (r > rdc_pkg::RADIX_MAX) r = rdc_pkg::RADIX_MAX;
        n = 0;
        if (v == 0) begin
            // zero still yields a single '0'
            remainders[0] = '0;
            n = 1;
        end else begin
            while (v != 0 && n < MAX_DIGITS) begin
                remainders[n] = rdc_pkg::t_digit'(v % r);
                v = v / r;
                n++;
            end
        end
        for (int k = n; k > 0; k--) begin
            if (remainders[k-1] < DECIMAL_SPAN)
                code = CHAR_ZERO + remainders[k-1];
            else
                code = CHAR_UPPER_A + remainders[k-1] - DECIMAL_SPAN;
            w.ch   = rdc_pkg::t_char'(code);
            w.last = (k == 1);
            expected_digits.push_back(w);
        end
    endfunction

    function void check_word(logic [rdc_pkg::M_TDATA_W-1:0] data, logic last);
        t_digit_word w;
        if (expected_digits.size() == 0) begin
            $error("unexpected word: digit_char %0d, last %0b", data[6:0], last);
            error_count++;
            return;
        end
        w = expected_digits.pop_front();
        if (data[6:0] !== w.ch) begin
            $error("digit_char mismatch: expected %0d, actual %0d", w.ch, data[6:0]);
            error_count++;
        end
        if (data[7] !== 1'b0) begin
            $error("pad bit mismatch: expected 0, actual %0b", data[7]);
            error_count++;
        end
        if (last !== w.last) begin
            $error("last mismatch: expected %0b, actual %0b", w.last, last);
            error_count++;
        end
    endfunction

    function int pending();
        return expected_digits.size();
    endfunction

endclass

module testbench;

    localparam int RANDOM_WORDS = 390;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 300;   // longer than one 16-digit conversion

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [rdc_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [rdc_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tlast;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;

    digit_scoreboard sb = new();

    radix_digit_converter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // sink side: random back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    // One input word; tvalid stays high across back-to-back words.
    task automatic send_word(input rdc_pkg::t_value value, input rdc_pkg::t_radix radix);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, radix, value};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(value, radix);
    endtask

    task automatic set_phase(input int idx, input int total);
        case (idx * 3 / total)
            0: begin
                tx_idle_pct = 8;
                rx_idle_pct = 81;
            end
            1: begin
                tx_idle_pct = 81;
                rx_idle_pct = 8;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    rdc_pkg::t_value directed_values[] = '{16'd1, 16'd65535, 16'd65535, 16'd65535, 16'd0,
                                           16'd0, 16'd255, 16'd10, 16'd15, 16'd1,
                                           16'd100, 16'd100, 16'd100, 16'd100, 16'd32768,
                                           16'd12345, 16'd65535, 16'd65535, 16'd1, 16'd0,
                                           16'd21845, 16'd43690, 16'd4096};
    rdc_pkg::t_radix directed_radices[] = '{5'd2, 5'd2, 5'd16, 5'd10, 5'd10,
                                            5'd2, 5'd16, 5'd11, 5'd16, 5'd16,
                                            5'd0, 5'd1, 5'd17, 5'd31, 5'd2,
                                            5'd10, 5'd3, 5'd7, 5'd0, 5'd31,
                                            5'd4, 5'd2, 5'd8};

    initial begin
        int              total;
        int              idx;
        int              width;
        rdc_pkg::t_value value;
        rdc_pkg::t_radix radix;
        total = directed_values.size() + RANDOM_WORDS;
        idx = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners: extremes of both fields, zero value, out-of-range radices
        foreach (directed_values[i]) begin
            set_phase(idx, total);
            send_word(directed_values[i], directed_radices[i]);
            idx++;
        end

        // random: digit count spread by drawing the value's bit width first
        repeat (RANDOM_WORDS) begin
            set_phase(idx, total);
            width = $urandom_range(16, 1);
            value = rdc_pkg::t_value'($urandom & ((32'd1 << width) - 1));
            if ($urandom_range(99) < 3)
                value = '0;
            if ($urandom_range(99) < 85)
                radix = rdc_pkg::t_radix'($urandom_range(16, 2));
            else
                radix = rdc_pkg::t_radix'($urandom_range(31, 0));
            send_word(value, radix);
            idx++;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rdc_pkg.sv
rtl/radix_digit_converter_core.sv
sim/testbench.sv
